>>> sv/assert_macros.svh
// Assertion macros used by bearing_range_calculator_top.
// Plain macros only; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BRA_ASSERT(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("assertion failed");
`define BRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BRA_ASSERT(lbl, clk, rstn, expr)
`define BRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> sv/bra_pkg.sv
// Shared constants, types and the sin/cos threshold tables.
// No dependencies.
package bra_pkg;
	localparam int COORD_BITS = 12;
	localparam int ANG_W = 9;
	localparam int BRG_W = 10;
	localparam int DIST_W = 13;
	localparam int DIST_MAX = 8191;
	localparam int TAB_W = 47;
	localparam int TAB_N = 46;
	localparam int KW = 6;
	localparam int SRCH_STEPS = 6;
	localparam int FIRST_STEP = 32;
	localparam int ANG_MAX_K = 44;
	localparam int DEG_45 = 45;
	localparam int DEG_89 = 89;
	localparam int DEG_90 = 90;
	localparam int DEG_179 = 179;
	localparam int DEG_180 = 180;
	localparam int DEG_359 = 359;
	localparam int DEG_360 = 360;
	localparam int ANG_LAT = 2 * SRCH_STEPS + 2;

	typedef logic [TAB_W-1:0] tab_t [0:TAB_N-1];

	typedef struct packed {
		logic swapped;
		logic dxneg;
		logic dyneg;
		logic eq;
		logic mnz;
		logic zero;
	} ang_ctl_t;

	function automatic int dist_lat(int cw);
		return cw + 5;
	endfunction

	function automatic int max_int(int a, int b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return p[123:60];
	endfunction

	// Q46 cos (sel=0) or sin (sel=1) of whole degrees, built in Q60.
	function automatic tab_t build_tab(logic sel);
		tab_t t;
		logic [63:0] x, x2, x3, x4, x5, x6, x7, x8, s1, c1, c, s, nc, ns, tmp;
		x = 64'h3243F6A8885A308D / 64'd180;
		x2 = mul_q60(x, x);
		x3 = mul_q60(x2, x);
		x4 = mul_q60(x2, x2);
		x5 = mul_q60(x4, x);
		x6 = mul_q60(x4, x2);
		x7 = mul_q60(x6, x);
		x8 = mul_q60(x4, x4);
		s1 = x - x3 / 64'd6 + x5 / 64'd120 - x7 / 64'd5040;
		c1 = (64'd1 << 60) - x2 / 64'd2 + x4 / 64'd24 - x6 / 64'd720 + x8 / 64'd40320;
		c = 64'd1 << 60;
		s = '0;
		for (int k = 0; k < TAB_N; k++) begin
			tmp = sel ? (s >> 14) : (c >> 14);
			t[k] = tmp[TAB_W-1:0];
			nc = mul_q60(c, c1) - mul_q60(s, s1);
			ns = mul_q60(s, c1) + mul_q60(c, s1);
			c = nc;
			s = ns;
		end
		return t;
	endfunction

	localparam tab_t COS_TAB = build_tab(1'b0);
	localparam tab_t SIN_TAB = build_tab(1'b1);
endpackage

>>> sv/bra_item_if.sv
// Input channel: valid/ready with the four marker positions.
// Depends on bra_pkg.
interface bra_item_if import bra_pkg::*; #(parameter int CW = COORD_BITS) ();
	logic valid;
	logic ready;
	logic [CW-1:0] front_x;
	logic [CW-1:0] front_y;
	logic [CW-1:0] back_x;
	logic [CW-1:0] back_y;
	logic [CW-1:0] target_x;
	logic [CW-1:0] target_y;
	logic [CW-1:0] home_x;
	logic [CW-1:0] home_y;
	modport source (output valid, front_x, front_y, back_x, back_y, target_x, target_y,
		home_x, home_y, input ready);
	modport sink (input valid, front_x, front_y, back_x, back_y, target_x, target_y,
		home_x, home_y, output ready);
endinterface

>>> sv/bra_result_if.sv
// Output channel: valid/ready with heading, bearings and distances.
// Depends on bra_pkg.
interface bra_result_if import bra_pkg::*; ();
	logic valid;
	logic ready;
	logic [ANG_W-1:0] heading;
	logic signed [BRG_W-1:0] angle_to_target;
	logic [DIST_W-1:0] distance_to_target;
	logic signed [BRG_W-1:0] angle_to_home;
	logic [DIST_W-1:0] distance_to_home;
	modport source (output valid, heading, angle_to_target, distance_to_target,
		angle_to_home, distance_to_home, input ready);
	modport sink (input valid, heading, angle_to_target, distance_to_target,
		angle_to_home, distance_to_home, output ready);
endinterface

>>> sv/bra_atan.sv
// Pipelined floor-degree atan2: octant fold, 6-step binary search on
// sin/cos thresholds (multiply stage + compare stage each), unfold. Uses bra_pkg.
module bra_atan import bra_pkg::*; #(
	parameter int CW = COORD_BITS,
	parameter int LAT = ANG_LAT
) (
	input logic clk,
	input logic en,
	input logic signed [CW:0] dx,
	input logic signed [CW:0] dy,
	output logic [ANG_W-1:0] angle
);
	localparam int PW = CW + TAB_W;
	localparam int NS = 2 * SRCH_STEPS;
	localparam int PAD = LAT - ANG_LAT;

	ang_ctl_t ctl_s [0:NS];
	logic [CW-1:0] mn_s [0:NS];
	logic [CW-1:0] mx_s [0:NS];
	logic [KW-1:0] lom_s [0:SRCH_STEPS-1];
	logic [KW-1:0] km_s [0:SRCH_STEPS-1];
	logic okm_s [0:SRCH_STEPS-1];
	logic [PW-1:0] pc_s [0:SRCH_STEPS-1];
	logic [PW-1:0] ps_s [0:SRCH_STEPS-1];
	logic [KW-1:0] lo_s [0:SRCH_STEPS-1];
	logic [ANG_W-1:0] ang_s;

	logic [CW:0] ndx, ndy;
	logic [CW-1:0] ax, ay;
	ang_ctl_t ctl_n;
	logic [KW-1:0] lo_in [0:SRCH_STEPS-1];
	logic [KW-1:0] k_n [0:SRCH_STEPS-1];
	logic ok_n [0:SRCH_STEPS-1];
	logic [PW-1:0] pc_n [0:SRCH_STEPS-1];
	logic [PW-1:0] ps_n [0:SRCH_STEPS-1];
	logic [KW-1:0] lo_n [0:SRCH_STEPS-1];
	logic [KW:0] kc;
	logic [KW-1:0] idx;
	logic [KW:0] af, bf;
	logic exact;
	logic [ANG_W-1:0] ang_n;

	always_comb begin
		ndx = -dx;
		ndy = -dy;
		ax = dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
		ay = dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
		ctl_n.swapped = ax > ay;
		ctl_n.dxneg = dx[CW];
		ctl_n.dyneg = dy[CW];
		ctl_n.eq = ax == ay;
		ctl_n.mnz = (ctl_n.swapped ? ay : ax) == '0;
		ctl_n.zero = (ax == '0) && (ay == '0);
	end

	always_comb begin
		for (int j = 0; j < SRCH_STEPS; j++) begin
			kc = '0;
			idx = '0;
			lo_in[j] = (j == 0) ? '0 : lo_s[(j == 0) ? 0 : j - 1];
			kc = {1'b0, lo_in[j]} + (KW + 1)'(FIRST_STEP >> j);
			ok_n[j] = kc <= (KW + 1)'(ANG_MAX_K);
			idx = ok_n[j] ? kc[KW-1:0] : '0;
			k_n[j] = idx;
			pc_n[j] = PW'(mn_s[2*j]) * PW'(COS_TAB[idx]);
			ps_n[j] = PW'(mx_s[2*j]) * PW'(SIN_TAB[idx]);
			lo_n[j] = (okm_s[j] && (pc_s[j] >= ps_s[j])) ? km_s[j] : lom_s[j];
		end
	end

	always_comb begin
		exact = ctl_s[NS].eq | ctl_s[NS].mnz;
		if (ctl_s[NS].eq)
			af = (KW + 1)'(DEG_45);
		else if (ctl_s[NS].mnz)
			af = '0;
		else
			af = {1'b0, lo_s[SRCH_STEPS-1]};
		if (ctl_s[NS].swapped)
			bf = exact ? (KW + 1)'(DEG_90) - af : (KW + 1)'(DEG_89) - af;
		else
			bf = af;
		priority if (ctl_s[NS].zero)
			ang_n = '0;
		else if (!ctl_s[NS].dxneg && !ctl_s[NS].dyneg)
			ang_n = ANG_W'(bf);
		else if (!ctl_s[NS].dxneg)
			ang_n = exact ? ANG_W'(DEG_180) - ANG_W'(bf) : ANG_W'(DEG_179) - ANG_W'(bf);
		else if (ctl_s[NS].dyneg)
			ang_n = ANG_W'(DEG_180) + ANG_W'(bf);
		else
			ang_n = exact ? ANG_W'(DEG_360) - ANG_W'(bf) : ANG_W'(DEG_359) - ANG_W'(bf);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s[0] <= ctl_n;
			mn_s[0] <= ctl_n.swapped ? ay : ax;
			mx_s[0] <= ctl_n.swapped ? ax : ay;
			for (int i = 1; i <= NS; i++) begin
				ctl_s[i] <= ctl_s[i-1];
				mn_s[i] <= mn_s[i-1];
				mx_s[i] <= mx_s[i-1];
			end
			for (int j = 0; j < SRCH_STEPS; j++) begin
				lom_s[j] <= lo_in[j];
				km_s[j] <= k_n[j];
				okm_s[j] <= ok_n[j];
				pc_s[j] <= pc_n[j];
				ps_s[j] <= ps_n[j];
				lo_s[j] <= lo_n[j];
			end
			ang_s <= ang_n;
		end
	end

	generate
		if (PAD == 0) begin : g_nopad
			assign angle = ang_s;
		end else begin : g_pad
			logic [ANG_W-1:0] pad_s [0:PAD-1];
			always_ff @(posedge clk) begin
				if (en) begin
					pad_s[0] <= ang_s;
					for (int i = 1; i < PAD; i++)
						pad_s[i] <= pad_s[i-1];
				end
			end
			assign angle = pad_s[PAD-1];
		end
	endgenerate
endmodule

>>> sv/bra_dist.sv
// Pipelined distance: abs, squares, sum, one root bit per stage, saturate.
// Uses bra_pkg.
module bra_dist import bra_pkg::*; #(
	parameter int CW = COORD_BITS,
	parameter int LAT = dist_lat(COORD_BITS)
) (
	input logic clk,
	input logic en,
	input logic signed [CW:0] dx,
	input logic signed [CW:0] dy,
	output logic [DIST_W-1:0] distance
);
	localparam int RB = CW + 1;
	localparam int RW = 2 * RB;
	localparam int REM_W = RB + 3;
	localparam int PAD = LAT - dist_lat(CW);

	logic [CW-1:0] ax_s1, ay_s1;
	logic [2*CW-1:0] sx_s2, sy_s2;
	logic [RW-1:0] rad_s [0:RB];
	logic [REM_W-1:0] rem_s [0:RB];
	logic [RB-1:0] root_s [0:RB];
	logic [DIST_W-1:0] dist_s;

	logic [CW:0] ndx, ndy;
	logic [REM_W-1:0] remx [0:RB-1];
	logic [REM_W-1:0] trial [0:RB-1];
	logic [RB-1:0] root_fin;

	always_comb begin
		ndx = -dx;
		ndy = -dy;
		for (int i = 0; i < RB; i++) begin
			remx[i] = {rem_s[i][REM_W-3:0], rad_s[i][RW-1:RW-2]};
			trial[i] = REM_W'({root_s[i], 2'b01});
		end
		root_fin = root_s[RB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
			ay_s1 <= dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
			sx_s2 <= (2*CW)'(ax_s1) * (2*CW)'(ax_s1);
			sy_s2 <= (2*CW)'(ay_s1) * (2*CW)'(ay_s1);
			rad_s[0] <= RW'(sx_s2) + RW'(sy_s2);
			rem_s[0] <= '0;
			root_s[0] <= '0;
			for (int i = 0; i < RB; i++) begin
				rad_s[i+1] <= rad_s[i] << 2;
				if (remx[i] >= trial[i]) begin
					rem_s[i+1] <= remx[i] - trial[i];
					root_s[i+1] <= {root_s[i][RB-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= remx[i];
					root_s[i+1] <= {root_s[i][RB-2:0], 1'b0};
				end
			end
			dist_s <= (root_fin > RB'(DIST_MAX)) ? DIST_W'(DIST_MAX) : DIST_W'(root_fin);
		end
	end

	generate
		if (PAD == 0) begin : g_nopad
			assign distance = dist_s;
		end else begin : g_pad
			logic [DIST_W-1:0] pad_s [0:PAD-1];
			always_ff @(posedge clk) begin
				if (en) begin
					pad_s[0] <= dist_s;
					for (int i = 1; i < PAD; i++)
						pad_s[i] <= pad_s[i-1];
				end
			end
			assign distance = pad_s[PAD-1];
		end
	endgenerate
endmodule

>>> sv/bearing_range_calculator_top.sv
// Throughput: one word per cycle; the whole pipeline advances together and
// holds when the output word is not taken.
// Reset clears the stage valid bits only; no clearing pass.
// Depends on bra_pkg, bra_item_if, bra_result_if, bra_atan, bra_dist.
`include "assert_macros.svh"
module bearing_range_calculator_top import bra_pkg::*; #(
	parameter int CW = COORD_BITS
) (
	input logic clk,
	input logic arst_n,
	bra_item_if.sink item,
	bra_result_if.source result
);
	localparam int LAT = max_int(ANG_LAT, dist_lat(CW));
	localparam int NST = LAT + 3;
	localparam logic signed [BRG_W-1:0] BRG_LIM = BRG_W'(DEG_360);

	logic [NST-1:0] vld_q;
	logic en;

	logic [CW-1:0] fx_s1, fy_s1, bx_s1, by_s1, tx_s1, ty_s1, hx_s1, hy_s1;
	logic signed [CW:0] hdx_s2, hdy_s2, tdx_s2, tdy_s2, mdx_s2, mdy_s2;
	logic [CW:0] cx, cy;
	logic [CW-1:0] cxh, cyh;

	logic [ANG_W-1:0] hd_a, tg_a, hm_a;
	logic [DIST_W-1:0] tg_d, hm_d;

	logic [ANG_W-1:0] hd_s3;
	logic signed [BRG_W-1:0] tg_s3, hm_s3;
	logic [DIST_W-1:0] tgd_s3, hmd_s3;

	assign en = !vld_q[NST-1] || result.ready;
	assign item.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], item.valid};
		end
	end

	always_comb begin
		cx = {1'b0, fx_s1} + {1'b0, bx_s1};
		cy = {1'b0, fy_s1} + {1'b0, by_s1};
		cxh = cx[CW:1];
		cyh = cy[CW:1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1 <= item.front_x;
			fy_s1 <= item.front_y;
			bx_s1 <= item.back_x;
			by_s1 <= item.back_y;
			tx_s1 <= item.target_x;
			ty_s1 <= item.target_y;
			hx_s1 <= item.home_x;
			hy_s1 <= item.home_y;
			hdx_s2 <= $signed({1'b0, bx_s1}) - $signed({1'b0, fx_s1});
			hdy_s2 <= $signed({1'b0, by_s1}) - $signed({1'b0, fy_s1});
			tdx_s2 <= $signed({1'b0, tx_s1}) - $signed({1'b0, cxh});
			tdy_s2 <= $signed({1'b0, ty_s1}) - $signed({1'b0, cyh});
			mdx_s2 <= $signed({1'b0, hx_s1}) - $signed({1'b0, cxh});
			mdy_s2 <= $signed({1'b0, hy_s1}) - $signed({1'b0, cyh});
			hd_s3 <= hd_a;
			tg_s3 <= $signed(BRG_W'(tg_a)) - $signed(BRG_W'(hd_a));
			hm_s3 <= $signed(BRG_W'(hm_a)) - $signed(BRG_W'(hd_a));
			tgd_s3 <= tg_d;
			hmd_s3 <= hm_d;
		end
	end

	bra_atan #(.CW(CW), .LAT(LAT)) u_head (
		.clk(clk), .en(en), .dx(hdx_s2), .dy(hdy_s2), .angle(hd_a));
	bra_atan #(.CW(CW), .LAT(LAT)) u_tgt_ang (
		.clk(clk), .en(en), .dx(tdx_s2), .dy(tdy_s2), .angle(tg_a));
	bra_atan #(.CW(CW), .LAT(LAT)) u_home_ang (
		.clk(clk), .en(en), .dx(mdx_s2), .dy(mdy_s2), .angle(hm_a));
	bra_dist #(.CW(CW), .LAT(LAT)) u_tgt_dist (
		.clk(clk), .en(en), .dx(tdx_s2), .dy(tdy_s2), .distance(tg_d));
	bra_dist #(.CW(CW), .LAT(LAT)) u_home_dist (
		.clk(clk), .en(en), .dx(mdx_s2), .dy(mdy_s2), .distance(hm_d));

	assign result.valid = vld_q[NST-1];
	assign result.heading = hd_s3;
	assign result.angle_to_target = tg_s3;
	assign result.distance_to_target = tgd_s3;
	assign result.angle_to_home = hm_s3;
	assign result.distance_to_home = hmd_s3;

	`BRA_ASSERT(a_head_rng, clk, arst_n, !result.valid || (result.heading < ANG_W'(DEG_360)))
	`BRA_ASSERT(a_tgt_rng, clk, arst_n, !result.valid || ((result.angle_to_target < BRG_LIM) && (result.angle_to_target > -BRG_LIM)))
	`BRA_ASSERT(a_home_rng, clk, arst_n, !result.valid || ((result.angle_to_home < BRG_LIM) && (result.angle_to_home > -BRG_LIM)))
	`BRA_ASSERT_NEXT(a_stall_hold, clk, arst_n, result.valid && !result.ready, $stable(vld_q))
endmodule

>>> dv/testbench.sv
// Self-checking testbench for bearing_range_calculator_top: directed table, then random words.
// Depends on bra_pkg, bra_item_if, bra_result_if and the block's RTL.
module testbench import bra_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1380;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [ANG_W-1:0] heading;
		logic signed [BRG_W-1:0] angle_to_target;
		logic [DIST_W-1:0] distance_to_target;
		logic signed [BRG_W-1:0] angle_to_home;
		logic [DIST_W-1:0] distance_to_home;
	} bearing_t;

	typedef struct {
		logic [COORD_BITS-1:0] c [8];
		bit typed;
		bearing_t want;
	} row_t;

	logic clk;
	logic arst_n;
	bra_item_if item_ch ();
	bra_result_if res_ch ();

	bearing_range_calculator_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch)
	);

	logic [63:0] cos_q46 [TAB_N];
	logic [63:0] sin_q46 [TAB_N];
	bearing_t pending_bearings [$];
	row_t rows [$];
	int errors = 0;
	int cycles = 0;
	int tx_idle = 0;
	int rx_idle = 0;
	bit rx_hold = 0;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	function automatic void make_trig_tables();
		logic [63:0] x, x2, x4, x6, s1, c1, c, s, nc;
		x = 64'h3243F6A8885A308D / 64'd180;
		x2 = q60_mul(x, x);
		x4 = q60_mul(x2, x2);
		x6 = q60_mul(x4, x2);
		s1 = x - q60_mul(x2, x) / 64'd6 + q60_mul(x4, x) / 64'd120
			- q60_mul(x6, x) / 64'd5040;
		c1 = (64'd1 << 60) - x2 / 64'd2 + x4 / 64'd24 - x6 / 64'd720
			+ q60_mul(x4, x4) / 64'd40320;
		c = 64'd1 << 60;
		s = 64'd0;
		for (int k = 0; k < TAB_N; k++) begin
			cos_q46[k] = c >> 14;
			sin_q46[k] = s >> 14;
			nc = q60_mul(c, c1) - q60_mul(s, s1);
			s = q60_mul(s, c1) + q60_mul(c, s1);
			c = nc;
		end
	endfunction

	function automatic int floor_bearing(longint dx, longint dy);
		longint ax, ay, mn, mx;
		bit swapped, exact;
		int af, bf;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		swapped = ax > ay;
		mn = swapped ? ay : ax;
		mx = swapped ? ax : ay;
		af = 0;
		exact = 1;
		if (mx == 0)
			return 0;
		if (mn == mx) begin
			af = 45;
		end else if (mn != 0) begin
			exact = 0;
			for (int k = 1; k < 45; k++) begin
				if (64'(mn) * cos_q46[k] >= 64'(mx) * sin_q46[k])
					af = k;
				else
					break;
			end
		end
		bf = swapped ? (exact ? 90 - af : 89 - af) : af;
		if (dx >= 0 && dy >= 0)
			return bf;
		if (dx >= 0)
			return exact ? 180 - bf : 179 - bf;
		if (dy < 0)
			return 180 + bf;
		return exact ? 360 - bf : 359 - bf;
	endfunction

	function automatic int range_px(longint dx, longint dy);
		longint unsigned n, res, b;
		n = dx * dx + dy * dy;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res > DIST_MAX ? DIST_MAX : int'(res);
	endfunction

	function automatic bearing_t predict_bearing(logic [COORD_BITS-1:0] c [8]);
		bearing_t r;
		longint v [8];
		longint cx, cy;
		int head;
		for (int i = 0; i < 8; i++)
			v[i] = c[i];
		cx = (v[0] + v[2]) / 2;
		cy = (v[1] + v[3]) / 2;
		head = floor_bearing(v[2] - v[0], v[3] - v[1]);
		r.heading = head;
		r.angle_to_target = floor_bearing(v[4] - cx, v[5] - cy) - head;
		r.distance_to_target = range_px(v[4] - cx, v[5] - cy);
		r.angle_to_home = floor_bearing(v[6] - cx, v[7] - cy) - head;
		r.distance_to_home = range_px(v[6] - cx, v[7] - cy);
		return r;
	endfunction

	function automatic void add_row(int a, int b, int c, int d, int e, int f, int g, int h,
		bit typed = 0, int e0 = 0, int e1 = 0, int e2 = 0, int e3 = 0, int e4 = 0);
		row_t r;
		r.c = '{a, b, c, d, e, f, g, h};
		r.typed = typed;
		r.want = '{e0, e1, e2, e3, e4};
		rows.push_back(r);
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
		errors++;
	endtask

	task automatic send_word(logic [COORD_BITS-1:0] c [8], bit typed, bearing_t want);
		while ($urandom_range(99) < tx_idle) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		{item_ch.front_x, item_ch.front_y, item_ch.back_x, item_ch.back_y,
			item_ch.target_x, item_ch.target_y, item_ch.home_x, item_ch.home_y} =
			{c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]};
		item_ch.valid = 1'b1;
		do
			@(posedge clk);
		while (!item_ch.ready);
		pending_bearings.push_back(typed ? want : predict_bearing(c));
		@(negedge clk);
	endtask

	function automatic logic [COORD_BITS-1:0] rand_coord(int mode, int base);
		case (mode)
			0: begin
				return $urandom_range(4095);
			end
			1: begin
				return base + $urandom_range(8) - 4;
			end
			default: begin
				return $urandom_range(1) ? 12'hFFF - $urandom_range(3) : $urandom_range(3);
			end
		endcase
	endfunction

	always @(posedge clk) begin
		bearing_t w;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("bearing_range_calculator_top regression: fail");
			$finish;
		end
		if (res_ch.valid && res_ch.ready) begin
			if (pending_bearings.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				w = pending_bearings.pop_front();
				if (res_ch.heading !== w.heading)
					report_mismatch("heading", res_ch.heading, w.heading);
				if (res_ch.angle_to_target !== w.angle_to_target)
					report_mismatch("angle_to_target", res_ch.angle_to_target,
						w.angle_to_target);
				if (res_ch.distance_to_target !== w.distance_to_target)
					report_mismatch("distance_to_target", res_ch.distance_to_target,
						w.distance_to_target);
				if (res_ch.angle_to_home !== w.angle_to_home)
					report_mismatch("angle_to_home", res_ch.angle_to_home, w.angle_to_home);
				if (res_ch.distance_to_home !== w.distance_to_home)
					report_mismatch("distance_to_home", res_ch.distance_to_home,
						w.distance_to_home);
			end
		end
	end

	always @(negedge clk)
		res_ch.ready = !rx_hold && ($urandom_range(99) >= rx_idle);

	initial begin
		logic [COORD_BITS-1:0] c [8];
		bearing_t none;
		int mode, base;
		none = '0;
		arst_n = 1'b0;
		res_ch.ready = 1'b0;
		item_ch.valid = 1'b0;
		{item_ch.front_x, item_ch.front_y, item_ch.back_x, item_ch.back_y,
			item_ch.target_x, item_ch.target_y, item_ch.home_x, item_ch.home_y} = '0;
		make_trig_tables();

		add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 1, 0, 0, 0, 0, 0);
		add_row(0, 0, 0, 4095, 0, 4095, 0, 0, 1, 0, 0, 2048, 180, 2047);
		add_row(4095, 4095, 0, 0, 4095, 4095, 0, 0, 1, 225, -180, 2896, 0, 2894);
		add_row(0, 0, 0, 0, 4095, 4095, 4095, 0);
		add_row(100, 100, 200, 100, 150, 200, 150, 0);
		add_row(100, 100, 100, 0, 0, 100, 200, 100);
		add_row(200, 100, 100, 100, 150, 150, 150, 50);
		add_row(100, 100, 200, 200, 200, 150, 100, 150);
		add_row(200, 200, 100, 100, 100, 200, 200, 100);
		add_row(100, 200, 200, 100, 151, 150, 149, 150);
		add_row(200, 100, 100, 200, 300, 300, 0, 0);
		add_row(1000, 1000, 1001, 3000, 1000, 3000, 4095, 1);
		add_row(3000, 1000, 1000, 1001, 0, 4095, 4095, 4095);
		add_row(0, 4095, 4095, 0, 2047, 2047, 2048, 2048);
		add_row(7, 3, 4, 7, 2048, 0, 0, 2048);
		add_row(2731, 1365, 1365, 2730, 4000, 100, 100, 4000);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle = 27;
		rx_idle = 76;
		foreach (rows[i])
			send_word(rows[i].c, rows[i].typed, rows[i].want);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3) begin
				tx_idle = 76;
				rx_idle = 27;
			end
			if (n == 2 * N_RANDOM / 3) begin
				tx_idle = 0;
				rx_idle = 0;
				fork
					begin
						rx_hold = 1'b1;
						repeat (200) @(negedge clk);
						rx_hold = 1'b0;
					end
				join_none
			end
			mode = $urandom_range(9) < 6 ? 0 : $urandom_range(1, 2);
			base = $urandom_range(4, 4091);
			for (int k = 0; k < 8; k++)
				c[k] = rand_coord(mode, base);
			if ($urandom_range(9) == 0)
				c[2 + 2 * $urandom_range(2)] = c[0];
			send_word(c, 0, none);
		end
		item_ch.valid = 1'b0;

		while (pending_bearings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("bearing_range_calculator_top regression: pass");
		else
			$display("bearing_range_calculator_top regression: fail");
		$finish;
	end
endmodule
